[design/fpa_pkg.sv]
// ----------------------------------------------------------------------------
// fpa_pkg
// Shared types and constants of the fixed partition allocator: command and
// status codes, register indexes, field widths and the packet that walks the
// cell row.
// ----------------------------------------------------------------------------
`default_nettype none

package fpa_pkg;

  // Field widths of the request and response transactions
  localparam int CMD_W     = 2;
  localparam int IDX_W     = 4;
  localparam int REQ_W     = 16;
  localparam int OWNER_W   = 8;
  localparam int STATUS_W  = 2;
  localparam int FRAG_W    = 24;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DAT_W = 5;

  localparam logic [FRAG_W-1:0] FRAG_MAX = {FRAG_W{1'b1}};

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FIT_MODE   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PART_COUNT = 4'd1;

  localparam logic [CFG_DAT_W-1:0] PART_COUNT_RESET = 5'd16;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD  = 2'd0,
    CMD_ALLOC = 2'd1,
    CMD_FREE  = 2'd2
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK          = 2'd0,
    STAT_NO_FIT      = 2'd1,
    STAT_ALREADY_FREE = 2'd2,
    STAT_BAD_INDEX   = 2'd3
  } status_e;

  // Command packet handed from cell to cell
  typedef struct packed {
    logic               valid;
    logic [CMD_W-1:0]   cmd;
    logic [IDX_W-1:0]   idx;
    logic [REQ_W-1:0]   req;
    logic [OWNER_W-1:0] owner;
    logic               last;
    logic               freed;
    logic [OWNER_W-1:0] prev_owner;
  } pkt_t;

endpackage

`default_nettype wire

[design/fpa_if.sv]
// ----------------------------------------------------------------------------
// fpa_if
// Valid/ready channels of the allocator: request, response and register
// write.
// ----------------------------------------------------------------------------
`default_nettype none

interface fpa_req_if;
  logic                        valid;
  logic                        ready;
  logic [fpa_pkg::CMD_W-1:0]   cmd;
  logic [fpa_pkg::IDX_W-1:0]   part_index;
  logic [fpa_pkg::REQ_W-1:0]   request_size;
  logic [fpa_pkg::OWNER_W-1:0] owner_id;
  logic                        last_request;

  modport source (output valid, cmd, part_index, request_size, owner_id,
                  last_request, input ready);
  modport sink   (input valid, cmd, part_index, request_size, owner_id,
                  last_request, output ready);
endinterface

interface fpa_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [fpa_pkg::STATUS_W-1:0] status;
  logic [fpa_pkg::IDX_W-1:0]    granted_partition;
  logic [fpa_pkg::REQ_W-1:0]    leftover;
  logic [fpa_pkg::FRAG_W-1:0]   frag_total;
  logic [fpa_pkg::OWNER_W-1:0]  prev_owner;

  modport source (output valid, status, granted_partition, leftover, frag_total,
                  prev_owner, input ready);
  modport sink   (input valid, status, granted_partition, leftover, frag_total,
                  prev_owner, output ready);
endinterface

interface fpa_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [fpa_pkg::CFG_IDX_W-1:0] index;
  logic [fpa_pkg::CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[design/fpa_cell.sv]
// ----------------------------------------------------------------------------
// fpa_cell
// One partition slot: holds size, busy flag and owner, applies load and free
// commands addressed to it, claims the slot on a committed grant to it, and
// updates the running fit candidate as the command packet passes through.
// ----------------------------------------------------------------------------
`default_nettype none

module fpa_cell #(
  parameter int SIZE_BITS  = 16,
  parameter int IW         = 4,
  parameter int CNT_BITS   = 5,
  parameter int CELL_INDEX = 0
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        fit_mode_i,
  input  wire logic [CNT_BITS-1:0]         live_count_i,
  input  wire fpa_pkg::pkt_t               pkt_i,
  input  wire logic                        pick_valid_i,
  input  wire logic [IW-1:0]               pick_idx_i,
  input  wire logic [SIZE_BITS-1:0]        pick_size_i,
  output fpa_pkg::pkt_t                    pkt_o,
  output logic                             pick_valid_o,
  output logic [IW-1:0]                    pick_idx_o,
  output logic [SIZE_BITS-1:0]             pick_size_o,
  input  wire logic                        commit_i,
  input  wire logic [IW-1:0]               commit_idx_i,
  input  wire logic [fpa_pkg::OWNER_W-1:0] commit_owner_i
);
  import fpa_pkg::*;

  localparam int CW = (SIZE_BITS > REQ_W) ? SIZE_BITS : REQ_W;
  localparam logic [IW-1:0] MY_IDX = IW'(CELL_INDEX);

  logic [SIZE_BITS-1:0] size_q, size_d;
  logic                 busy_q, busy_d;
  logic [OWNER_W-1:0]   owner_q, owner_d;

  pkt_t                 pkt_q, pkt_d;
  logic                 pick_valid_q, pick_valid_d;
  logic [IW-1:0]        pick_idx_q, pick_idx_d;
  logic [SIZE_BITS-1:0] pick_size_q, pick_size_d;

  logic live, hit, fits, take;

  assign live = CNT_BITS'(CELL_INDEX) < live_count_i;
  assign hit  = (int'(pkt_i.idx) == CELL_INDEX) && live;
  assign fits = live && !busy_q && (CW'(size_q) >= CW'(pkt_i.req));
  assign take = fits && (!pick_valid_i || (fit_mode_i && (size_q < pick_size_i)));

  // Apply commands to the slot and pass the packet on
  always_comb begin
    size_d       = size_q;
    busy_d       = busy_q;
    owner_d      = owner_q;
    pkt_d        = pkt_i;
    pick_valid_d = pick_valid_i;
    pick_idx_d   = pick_idx_i;
    pick_size_d  = pick_size_i;
    if (pkt_i.valid) begin
      case (pkt_i.cmd)
        CMD_LOAD: begin
          if (hit) begin
            size_d  = SIZE_BITS'(pkt_i.req);
            busy_d  = 1'b0;
            owner_d = '0;
          end
        end
        CMD_ALLOC: begin
          if (take) begin
            pick_valid_d = 1'b1;
            pick_idx_d   = MY_IDX;
            pick_size_d  = size_q;
          end
        end
        CMD_FREE: begin
          if (hit && busy_q) begin
            pkt_d.freed      = 1'b1;
            pkt_d.prev_owner = owner_q;
            busy_d           = 1'b0;
            owner_d          = '0;
          end
        end
        default: begin
        end
      endcase
    end
    // Claim the slot once the granted allocation is committed
    if (commit_i && (commit_idx_i == MY_IDX)) begin
      busy_d  = 1'b1;
      owner_d = commit_owner_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q       <= '0;
      busy_q       <= 1'b0;
      owner_q      <= '0;
      pkt_q        <= '0;
      pick_valid_q <= 1'b0;
    end else begin
      size_q       <= size_d;
      busy_q       <= busy_d;
      owner_q      <= owner_d;
      pkt_q        <= pkt_d;
      pick_valid_q <= pick_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pick_idx_q  <= pick_idx_d;
    pick_size_q <= pick_size_d;
  end

  assign pkt_o        = pkt_q;
  assign pick_valid_o = pick_valid_q;
  assign pick_idx_o   = pick_idx_q;
  assign pick_size_o  = pick_size_q;

endmodule

`default_nettype wire

[design/fixed_partition_allocator.sv]
// ----------------------------------------------------------------------------
// fixed_partition_allocator
// Fixed partition table with first-fit or best-fit allocation, built as a
// row of partition cells that a command packet walks through.
// ----------------------------------------------------------------------------
// Usage:
//   req_i  carries load, allocate and free commands; one response leaves on
//          rsp_o for each accepted request.
//   cfg_i  writes fit_mode (index 0) and partition_count (index 1); writes to
//          other indexes are ignored. Write only while no request is pending.
// Flow:
//   Every command is registered at the head and travels the whole cell row,
//   one cell per cycle; its result is then settled in hold registers and
//   committed to the output register. The row holds one command at a time;
//   the next request is accepted in the cycle after the commit.
// Stall:
//   The response sits in an output register. While it waits, the next request
//   is accepted and walks the row; it holds at commit until the output
//   register frees.
// Reset:
//   All partitions are free with size 0 and owner 0, the fragmentation sum is
//   0, fit_mode is first fit and partition_count is 16.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_partition_allocator #(
  parameter int PARTITIONS = 16,
  parameter int SIZE_BITS  = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  fpa_req_if.sink   req_i,
  fpa_rsp_if.source rsp_o,
  fpa_cfg_if.sink   cfg_i
);
  import fpa_pkg::*;

  localparam int IW       = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1;
  localparam int CNT_BITS = $clog2(PARTITIONS + 1);
  localparam int CW       = (SIZE_BITS > REQ_W) ? SIZE_BITS : REQ_W;
  localparam int SW       = ((CW > FRAG_W) ? CW : FRAG_W) + 1;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_WALK   = 3'b010,
    S_COMMIT = 3'b100
  } state_e;

  state_e state_q, state_d;

  // Configuration registers
  logic                 fit_mode_q;
  logic [CFG_DAT_W-1:0] count_q;
  logic [CNT_BITS-1:0]  live_count;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fit_mode_q <= 1'b0;
      count_q    <= PART_COUNT_RESET;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == CFG_FIT_MODE) begin
        fit_mode_q <= cfg_i.data[0];
      end else if (cfg_i.index == CFG_PART_COUNT) begin
        count_q <= cfg_i.data;
      end
    end
  end

  assign live_count = (int'(count_q) > PARTITIONS) ? CNT_BITS'(PARTITIONS)
                                                   : CNT_BITS'(count_q);

  // Cell row
  pkt_t                 chain    [PARTITIONS+1];
  logic                 pick_v   [PARTITIONS+1];
  logic [IW-1:0]        pick_idx [PARTITIONS+1];
  logic [SIZE_BITS-1:0] pick_sz  [PARTITIONS+1];
  logic [PARTITIONS:0]  chain_v;

  pkt_t head_q, head_d;
  logic accept, rsp_free, commit;

  assign req_i.ready = (state_q == S_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign rsp_free    = !rsp_o.valid || rsp_o.ready;
  assign commit      = (state_q == S_COMMIT) && rsp_free;

  always_comb begin
    head_d            = '0;
    head_d.valid      = accept;
    head_d.cmd        = req_i.cmd;
    head_d.idx        = req_i.part_index;
    head_d.req        = req_i.request_size;
    head_d.owner      = req_i.owner_id;
    head_d.last       = req_i.last_request;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
    end else begin
      head_q <= head_d;
    end
  end

  assign chain[0]    = head_q;
  assign pick_v[0]   = 1'b0;
  assign pick_idx[0] = '0;
  assign pick_sz[0]  = '0;

  // Hold values of the settled result
  logic [STATUS_W-1:0] hold_status_q, hold_status_d;
  logic [IDX_W-1:0]    hold_granted_q, hold_granted_d;
  logic [REQ_W-1:0]    hold_left_q, hold_left_d;
  logic [FRAG_W-1:0]   hold_frag_q, hold_frag_d;
  logic [OWNER_W-1:0]  hold_prev_q, hold_prev_d;
  logic                hold_grant_q, hold_grant_d;
  logic                hold_clear_q, hold_clear_d;
  logic [IW-1:0]       hold_idx_q;
  logic [OWNER_W-1:0]  hold_owner_q;

  genvar k;
  generate
    for (k = 0; k < PARTITIONS; k++) begin : g_cell
      fpa_cell #(
        .SIZE_BITS  (SIZE_BITS),
        .IW         (IW),
        .CNT_BITS   (CNT_BITS),
        .CELL_INDEX (k)
      ) u_cell (
        .clk_i          (clk_i),
        .rst_ni         (rst_ni),
        .fit_mode_i     (fit_mode_q),
        .live_count_i   (live_count),
        .pkt_i          (chain[k]),
        .pick_valid_i   (pick_v[k]),
        .pick_idx_i     (pick_idx[k]),
        .pick_size_i    (pick_sz[k]),
        .pkt_o          (chain[k+1]),
        .pick_valid_o   (pick_v[k+1]),
        .pick_idx_o     (pick_idx[k+1]),
        .pick_size_o    (pick_sz[k+1]),
        .commit_i       (commit && hold_grant_q),
        .commit_idx_i   (hold_idx_q),
        .commit_owner_i (hold_owner_q)
      );
    end
    for (k = 0; k <= PARTITIONS; k++) begin : g_valid
      assign chain_v[k] = chain[k].valid;
    end
  endgenerate

  // Settle the result from the packet leaving the row
  pkt_t                tail;
  logic                bad_idx;
  logic [CW-1:0]       left_full;
  logic [SW-1:0]       frag_sum_w;
  logic [FRAG_W-1:0]   frag_q;

  assign tail       = chain[PARTITIONS];
  assign bad_idx    = !(int'(tail.idx) < int'(live_count));
  assign left_full  = CW'(pick_sz[PARTITIONS]) - CW'(tail.req);
  assign frag_sum_w = SW'(frag_q) + SW'(left_full);

  always_comb begin
    hold_status_d  = STAT_OK;
    hold_granted_d = '0;
    hold_left_d    = '0;
    hold_frag_d    = frag_q;
    hold_prev_d    = '0;
    hold_grant_d   = 1'b0;
    hold_clear_d   = 1'b0;
    case (tail.cmd)
      CMD_LOAD: begin
        if (bad_idx) begin
          hold_status_d = STAT_BAD_INDEX;
        end else begin
          hold_granted_d = tail.idx;
        end
      end
      CMD_ALLOC: begin
        hold_clear_d = tail.last;
        if (!pick_v[PARTITIONS]) begin
          hold_status_d = STAT_NO_FIT;
        end else begin
          hold_grant_d   = 1'b1;
          hold_granted_d = IDX_W'(pick_idx[PARTITIONS]);
          hold_left_d    = REQ_W'(left_full);
          hold_frag_d    = (frag_sum_w > SW'(FRAG_MAX)) ? FRAG_MAX
                                                        : FRAG_W'(frag_sum_w);
        end
      end
      CMD_FREE: begin
        if (bad_idx) begin
          hold_status_d = STAT_BAD_INDEX;
        end else if (!tail.freed) begin
          hold_status_d = STAT_ALREADY_FREE;
        end else begin
          hold_granted_d = tail.idx;
          hold_prev_d    = tail.prev_owner;
        end
      end
      default: begin
        hold_status_d = STAT_BAD_INDEX;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (tail.valid) begin
      hold_status_q  <= hold_status_d;
      hold_granted_q <= hold_granted_d;
      hold_left_q    <= hold_left_d;
      hold_frag_q    <= hold_frag_d;
      hold_prev_q    <= hold_prev_d;
      hold_clear_q   <= hold_clear_d;
      hold_idx_q     <= pick_idx[PARTITIONS];
      hold_owner_q   <= tail.owner;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_grant_q <= 1'b0;
    end else if (tail.valid) begin
      hold_grant_q <= hold_grant_d;
    end
  end

  // Sequence: idle, walk the row, commit
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (accept) state_d = S_WALK;
      S_WALK:   if (tail.valid) state_d = S_COMMIT;
      S_COMMIT: if (rsp_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      frag_q  <= '0;
    end else begin
      state_q <= state_d;
      if (commit) begin
        frag_q <= hold_clear_q ? '0 : hold_frag_q;
      end
    end
  end

  // Output register
  logic                rsp_valid_q;
  logic [STATUS_W-1:0] rsp_status_q;
  logic [IDX_W-1:0]    rsp_granted_q;
  logic [REQ_W-1:0]    rsp_left_q;
  logic [FRAG_W-1:0]   rsp_frag_q;
  logic [OWNER_W-1:0]  rsp_prev_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (commit) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      rsp_status_q  <= hold_status_q;
      rsp_granted_q <= hold_granted_q;
      rsp_left_q    <= hold_left_q;
      rsp_frag_q    <= hold_frag_q;
      rsp_prev_q    <= hold_prev_q;
    end
  end

  assign rsp_o.valid             = rsp_valid_q;
  assign rsp_o.status            = rsp_status_q;
  assign rsp_o.granted_partition = rsp_granted_q;
  assign rsp_o.leftover          = rsp_left_q;
  assign rsp_o.frag_total        = rsp_frag_q;
  assign rsp_o.prev_owner        = rsp_prev_q;

  // Checks
  a_one_packet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(chain_v) <= 1)
    else $error("more than one packet in the cell row");

  a_tail_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail.valid |-> (state_q == S_WALK))
    else $error("packet left the row outside the walk");

  a_accept_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_WALK) && head_q.valid)
    else $error("accepted request did not enter the row");

  a_commit_loads_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> rsp_o.valid && (state_q == S_IDLE))
    else $error("commit did not produce a response");

endmodule

`default_nettype wire

[tb/sv/fpa_checker.sv]
// ----------------------------------------------------------------------------
// fpa_checker
// Watches the request, response and register write channels of the fixed
// partition allocator. Keeps a shadow partition table, works out the reply
// of every accepted request and compares each accepted reply, field by
// field, with the oldest one outstanding.
// ----------------------------------------------------------------------------
`default_nettype none

module fpa_checker (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  fpa_req_if         req_mon,
  fpa_rsp_if         rsp_mon,
  fpa_cfg_if         cfg_mon,
  output int unsigned pending_o,
  output int unsigned fail_count_o
);

  timeunit 1ns;
  timeprecision 1ps;

  import fpa_pkg::*;

  localparam int PART_NUM  = 16;

  typedef struct packed {
    status_e             status;
    logic [IDX_W-1:0]    part;
    logic [REQ_W-1:0]    leftover;
    logic [FRAG_W-1:0]   frag;
    logic [OWNER_W-1:0]  prev_owner;
  } alloc_reply_t;

  // Shadow table and register copies
  logic [REQ_W-1:0]     part_size  [PART_NUM];
  logic                 part_busy  [PART_NUM];
  logic [OWNER_W-1:0]   part_owner [PART_NUM];
  logic [FRAG_W-1:0]    frag_sum;
  logic                 fit_best;
  logic [CFG_DAT_W-1:0] part_cfg;

  alloc_reply_t due_replies[$];
  int unsigned  fail_count;
  int unsigned  reply_num;

  // Print one line per mismatch and count it
  task automatic flag_error(input string msg);
    $display("[%0t] ERROR %s", $realtime, msg);
    fail_count++;
  endtask

  // Apply one command to the shadow table and return its reply
  function automatic alloc_reply_t serve_cmd(input logic [CMD_W-1:0]   cmd,
                                             input logic [IDX_W-1:0]   idx,
                                             input logic [REQ_W-1:0]   size,
                                             input logic [OWNER_W-1:0] owner,
                                             input logic               last);
    alloc_reply_t r;
    int           n;
    int           pick;
    int           j;
    logic [FRAG_W:0] sum;
    r    = '0;
    n    = (part_cfg > PART_NUM) ? PART_NUM : int'(part_cfg);
    pick = -1;
    case (cmd)
      CMD_LOAD: begin
        if (idx >= n) begin
          r.status = STAT_BAD_INDEX;
        end else begin
          part_size[idx]  = size;
          part_busy[idx]  = 1'b0;
          part_owner[idx] = '0;
          r.part          = idx;
        end
      end
      CMD_ALLOC: begin
        // first fit keeps the lowest match, best fit only moves on a strictly
        // smaller size so the lowest index wins ties
        for (j = 0; j < n; j++) begin
          if (!part_busy[j] && part_size[j] >= size) begin
            if (pick < 0) begin
              pick = j;
            end else if (fit_best && part_size[j] < part_size[pick]) begin
              pick = j;
            end
          end
        end
        if (pick < 0) begin
          r.status = STAT_NO_FIT;
        end else begin
          part_busy[pick]  = 1'b1;
          part_owner[pick] = owner;
          r.leftover       = part_size[pick] - size;
          sum              = frag_sum + r.leftover;
          frag_sum         = (sum > FRAG_MAX) ? FRAG_MAX : sum[FRAG_W-1:0];
          r.part           = pick[IDX_W-1:0];
        end
      end
      CMD_FREE: begin
        if (idx >= n) begin
          r.status = STAT_BAD_INDEX;
        end else if (!part_busy[idx]) begin
          r.status = STAT_ALREADY_FREE;
        end else begin
          r.prev_owner    = part_owner[idx];
          part_busy[idx]  = 1'b0;
          part_owner[idx] = '0;
          r.part          = idx;
        end
      end
      default: begin
        r.status = STAT_BAD_INDEX;
      end
    endcase
    // report the sum before a batch end clears it
    r.frag = frag_sum;
    if (cmd == CMD_ALLOC && last) begin
      frag_sum = '0;
    end
    return r;
  endfunction

  // Track registers, check replies, queue predictions
  always @(posedge clk_i or negedge rst_ni) begin
    alloc_reply_t want;
    int           k;
    if (!rst_ni) begin
      for (k = 0; k < PART_NUM; k++) begin
        part_size[k]  = '0;
        part_busy[k]  = 1'b0;
        part_owner[k] = '0;
      end
      frag_sum   = '0;
      fit_best   = 1'b0;
      part_cfg   = PART_COUNT_RESET;
      due_replies.delete();
      fail_count = 0;
      reply_num  = 0;
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          CFG_FIT_MODE:   fit_best = cfg_mon.data[0];
          CFG_PART_COUNT: part_cfg = cfg_mon.data;
          default: ;
        endcase
      end

      if (rsp_mon.valid && rsp_mon.ready) begin
        if (due_replies.size() == 0) begin
          flag_error($sformatf("reply %0d arrived with none outstanding", reply_num));
        end else begin
          want = due_replies.pop_front();
          if (rsp_mon.status !== want.status) begin
            flag_error($sformatf("reply %0d status: got %0d, expected %0d",
                                 reply_num, rsp_mon.status, want.status));
          end
          if (rsp_mon.granted_partition !== want.part) begin
            flag_error($sformatf("reply %0d granted_partition: got %0d, expected %0d",
                                 reply_num, rsp_mon.granted_partition, want.part));
          end
          if (rsp_mon.leftover !== want.leftover) begin
            flag_error($sformatf("reply %0d leftover: got %0d, expected %0d",
                                 reply_num, rsp_mon.leftover, want.leftover));
          end
          if (rsp_mon.frag_total !== want.frag) begin
            flag_error($sformatf("reply %0d frag_total: got %0d, expected %0d",
                                 reply_num, rsp_mon.frag_total, want.frag));
          end
          if (rsp_mon.prev_owner !== want.prev_owner) begin
            flag_error($sformatf("reply %0d prev_owner: got %0d, expected %0d",
                                 reply_num, rsp_mon.prev_owner, want.prev_owner));
          end
        end
        reply_num++;
      end

      if (req_mon.valid && req_mon.ready) begin
        due_replies.push_back(serve_cmd(req_mon.cmd, req_mon.part_index,
                                        req_mon.request_size, req_mon.owner_id,
                                        req_mon.last_request));
      end

      pending_o    <= due_replies.size();
      fail_count_o <= fail_count;
    end
  end

endmodule

`default_nettype wire

[tb/sv/fixed_partition_allocator_tb.sv]
// ----------------------------------------------------------------------------
// fixed_partition_allocator_tb
// Drives load, allocate and free transactions and register writes into the
// allocator: a directed opening over the corner cases, then phases of random
// traffic under first fit and best fit with various partition counts, one of
// them built to drive the fragmentation sum into saturation. Both sides
// insert random idle bursts. The checker beside the block does the scoring.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_partition_allocator_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import fpa_pkg::*;

  localparam logic [CMD_W-1:0] CMD_RESERVED = 2'd3;
  localparam int PHASES      = 12;
  localparam int HEAVY_PHASE = 4;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_WAIT  = 40;

  logic        clk_i   = 1'b0;
  logic        rst_ni  = 1'b0;
  logic        idle_on;
  int unsigned pending;
  int unsigned fail_count;
  int unsigned stall_cycles = 0;

  fpa_req_if req_if ();
  fpa_rsp_if rsp_if ();
  fpa_cfg_if cfg_if ();

  fixed_partition_allocator dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .cfg_i  (cfg_if)
  );

  fpa_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_mon      (req_if),
    .rsp_mon      (rsp_if),
    .cfg_mon      (cfg_if),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  always #4ns clk_i = ~clk_i;

  // Send one request transaction, with an optional idle burst ahead of it
  task automatic send_req(input logic [CMD_W-1:0]   cmd,
                          input logic [IDX_W-1:0]   idx,
                          input logic [REQ_W-1:0]   size,
                          input logic [OWNER_W-1:0] owner,
                          input logic               last);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    req_if.valid        <= 1'b1;
    req_if.cmd          <= cmd;
    req_if.part_index   <= idx;
    req_if.request_size <= size;
    req_if.owner_id     <= owner;
    req_if.last_request <= last;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
  endtask

  // Write one register; valid stays high for a following write
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] index,
                           input logic [CFG_DAT_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= index;
    cfg_if.data  <= data;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
  endtask

  task automatic set_config(input logic fit, input logic [CFG_DAT_W-1:0] count);
    cfg_write(CFG_FIT_MODE, {{(CFG_DAT_W-1){1'b0}}, fit});
    cfg_write(CFG_PART_COUNT, count);
    cfg_if.valid <= 1'b0;
  endtask

  // Drop valid and hold until every outstanding reply has been taken
  task automatic quiesce();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // One random transaction; the heavy mix loads near-full sizes and asks for
  // tiny ones so the fragmentation sum climbs to its ceiling
  task automatic send_random(input bit heavy_frag, input int live);
    logic [CMD_W-1:0] cmd;
    logic [IDX_W-1:0] idx;
    logic [REQ_W-1:0] size;
    int unsigned      roll;
    roll = $urandom_range(0, 99);
    if (heavy_frag) begin
      cmd = (roll < 45) ? CMD_LOAD : (roll < 90) ? CMD_ALLOC : CMD_FREE;
    end else begin
      cmd = (roll < 30) ? CMD_LOAD : (roll < 70) ? CMD_ALLOC :
            (roll < 95) ? CMD_FREE : CMD_RESERVED;
    end
    if (live > 0 && $urandom_range(0, 99) < 85) begin
      idx = IDX_W'($urandom_range(0, live - 1));
    end else begin
      idx = IDX_W'($urandom_range(0, 15));
    end
    if (heavy_frag) begin
      size = (cmd == CMD_LOAD) ? REQ_W'($urandom_range(16'hFF00, 16'hFFFF))
                               : REQ_W'($urandom_range(0, 255));
    end else begin
      case ($urandom_range(0, 9))
        0:             size = '0;
        1:             size = '1;
        2, 3, 4, 5, 6: size = REQ_W'($urandom_range(0, 255));
        default:       size = REQ_W'($urandom());
      endcase
    end
    send_req(cmd, idx, size, OWNER_W'($urandom_range(0, 255)),
             heavy_frag ? 1'b0 : ($urandom_range(0, 7) == 0));
  endtask

  // Reply side: random stall bursts while idling is on
  initial begin : reply_stall
    rsp_if.ready <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    rsp_if.ready <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (idle_on && $urandom_range(0, 11) == 0) begin
        rsp_if.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run when no channel moves a transaction for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int unsigned          phase;
    int unsigned          items;
    int                   live;
    logic                 fit;
    logic [CFG_DAT_W-1:0] count;

    idle_on             <= 1'b1;
    req_if.valid        <= 1'b0;
    req_if.cmd          <= CMD_LOAD;
    req_if.part_index   <= '0;
    req_if.request_size <= '0;
    req_if.owner_id     <= '0;
    req_if.last_request <= 1'b0;
    cfg_if.valid        <= 1'b0;
    cfg_if.index        <= CFG_FIT_MODE;
    cfg_if.data         <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset defaults, first fit, zero-size request, double free
    send_req(CMD_ALLOC, 4'd0, 16'd0, 8'hFF, 1'b0);
    send_req(CMD_FREE, 4'd0, 16'd0, 8'h00, 1'b0);
    send_req(CMD_FREE, 4'd0, 16'd0, 8'h00, 1'b0);
    send_req(CMD_LOAD, 4'd15, 16'hFFFF, 8'h00, 1'b0);
    send_req(CMD_LOAD, 4'd3, 16'd100, 8'h00, 1'b0);
    send_req(CMD_LOAD, 4'd5, 16'd50, 8'h00, 1'b0);
    send_req(CMD_ALLOC, 4'd0, 16'd55, 8'h5A, 1'b0);
    send_req(CMD_ALLOC, 4'd0, 16'hFFFF, 8'h00, 1'b0);
    // no fit, still ends the batch
    send_req(CMD_ALLOC, 4'd0, 16'hFFFF, 8'h01, 1'b1);
    send_req(CMD_RESERVED, 4'd0, 16'd0, 8'h00, 1'b0);
    send_req(CMD_FREE, 4'd15, 16'd0, 8'h00, 1'b0);

    // Best fit with a tie between two equal partitions
    quiesce();
    set_config(1'b1, 5'd16);
    send_req(CMD_LOAD, 4'd2, 16'd80, 8'h00, 1'b0);
    send_req(CMD_LOAD, 4'd6, 16'd80, 8'h00, 1'b0);
    send_req(CMD_LOAD, 4'd9, 16'd70, 8'h00, 1'b0);
    send_req(CMD_ALLOC, 4'd0, 16'd65, 8'h11, 1'b0);
    send_req(CMD_ALLOC, 4'd0, 16'd65, 8'h22, 1'b0);
    send_req(CMD_ALLOC, 4'd0, 16'd65, 8'h33, 1'b0);
    send_req(CMD_ALLOC, 4'd0, 16'd65, 8'h44, 1'b0);
    send_req(CMD_ALLOC, 4'd0, 16'd65, 8'h55, 1'b1);

    // Shrunk table: indexes past the count are rejected
    quiesce();
    set_config(1'b0, 5'd4);
    send_req(CMD_LOAD, 4'd4, 16'd10, 8'h00, 1'b0);
    send_req(CMD_FREE, 4'd15, 16'd0, 8'h00, 1'b0);
    send_req(CMD_FREE, 4'd3, 16'd0, 8'h00, 1'b0);
    send_req(CMD_LOAD, 4'd3, 16'd0, 8'h00, 1'b0);

    // Random phases over fit modes and partition counts
    for (phase = 0; phase < PHASES; phase++) begin
      quiesce();
      case (phase)
        0:           count = 5'd1;
        1:           count = 5'd16;
        2:           count = 5'd0;
        3:           count = 5'd31;
        HEAVY_PHASE: count = 5'd16;
        default:     count = CFG_DAT_W'($urandom_range(1, 16));
      endcase
      fit = (phase < 6) ? phase[0] : 1'($urandom_range(0, 1));
      set_config(fit, count);
      idle_on <= (phase != PHASES - 1) && ($urandom_range(0, 3) != 0);
      live  = (count > 16) ? 16 : int'(count);
      items = (phase == HEAVY_PHASE) ? 750 : 90;
      repeat (items) send_random(phase == HEAVY_PHASE, live);
    end

    quiesce();
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
